@@ hw/rtl/alist_pkg.sv @@
// Shared types, widths and codes for the array list engine.
// Depends on nothing; every other file but alist_ram refers to it by scoped names.
package alist_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int RES_W    = 42;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 3;
   localparam int CFG_W    = 11;

   localparam int REQ_BITS     = OP_W + ADDR_W + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS     = RES_W + ADDR_W + STATUS_W + CNT_W;
   localparam int RSP_TDATA_W  = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_SEARCH = 3'd2,
      OP_SUM    = 3'd3,
      OP_MAX    = 3'd4,
      OP_MIN    = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_RANGE     = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_PUT,
      S_DONE
   } state_type;

   // Sequencer to reduction unit.
   typedef struct packed {
      logic                clear;
      op_type              op;
      logic                valid;
      logic                first;
      logic [ADDR_W-1:0]   pos;
      logic [DATA_W-1:0]   key;
   } acc_ctrl_type;

   // Sequencer to top level when a request finishes.
   typedef struct packed {
      logic       load;
      op_type     op;
      status_type status;
      logic       ok;
   } done_type;

endpackage

@@ hw/rtl/array_list_engine.sv @@
// Top level of the array list engine: ports, length and capacity registers,
// result register. Uses alist_pkg, alist_ram, alist_seq and alist_acc.
//
// Channel   Direction  Handshake                 Carries
// req_*     in         req_tvalid / req_tready   one request: op, index, value
// rsp_*     out        rsp_tvalid / rsp_tready   one result per request
// csr_*     in         csr_valid / csr_ready     capacity_in_use write data
//
// Insert and delete walk (length - index) entries; search, sum, max and min
// walk the whole list. An insert writes the new element after the shift.
// The walk reads one entry per cycle, set by the single read port of the
// element memory.
// Reset clears the length to zero and the capacity to its full value; the
// element memory is not cleared, since only written entries are ever read.
// A result waits in its own register, so the next request is taken while
// the previous result is stalled; a second result waits until it drains.
module array_list_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request: op [2:0], index [12:3], value [44:13], zero fill above.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [alist_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // Result: result_value [41:0], position [51:42], status [54:52],
   // count [65:55], zero fill above.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [alist_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // Capacity register write.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [alist_pkg::CFG_W-1:0]          csr_data
);

   localparam int OP_LO  = 0;
   localparam int IDX_LO = OP_LO + alist_pkg::OP_W;
   localparam int VAL_LO = IDX_LO + alist_pkg::ADDR_W;

   logic [alist_pkg::CFG_W-1:0]          cap_ff, cap_in;
   logic [alist_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [alist_pkg::CNT_W-1:0]          cap_eff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [alist_pkg::RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                                 rsp_free;

   alist_pkg::op_type                    req_op;
   logic [alist_pkg::ADDR_W-1:0]         req_index;
   logic [alist_pkg::DATA_W-1:0]         req_value;

   logic                                 rd_en, wr_en;
   logic [alist_pkg::ADDR_W-1:0]         rd_addr, wr_addr;
   logic [alist_pkg::DATA_W-1:0]         rd_data, wr_data;
   alist_pkg::acc_ctrl_type              acc_ctrl;
   alist_pkg::done_type                  done;

   logic signed [alist_pkg::RES_W-1:0]   acc_result;
   logic                                 found;
   logic [alist_pkg::ADDR_W-1:0]         found_pos;
   alist_pkg::status_type                final_status;

   assign req_op    = alist_pkg::op_type'(req_tdata[IDX_LO-1:OP_LO]);
   assign req_index = req_tdata[VAL_LO-1:IDX_LO];
   assign req_value = req_tdata[VAL_LO+alist_pkg::DATA_W-1:VAL_LO];

   // The register may ask for more room than the store has; clamp it.
   always_comb begin
      if (32'(cap_ff) > 32'(alist_pkg::CAPACITY)) begin
         cap_eff = alist_pkg::CNT_W'(alist_pkg::CAPACITY);
      end else begin
         cap_eff = alist_pkg::CNT_W'(cap_ff);
      end
   end

   // The result register may load when it is empty or being emptied.
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   alist_ram #(
      .WIDTH (alist_pkg::DATA_W),
      .DEPTH (alist_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   alist_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_op),
      .req_index (req_index),
      .req_value (req_value),
      .count     (count_ff),
      .cap_eff   (cap_eff),
      .rsp_free  (rsp_free),
      .rd_data   (rd_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .acc_ctrl  (acc_ctrl),
      .done      (done)
   );

   alist_acc u_acc (
      .clock    (clock),
      .ctrl     (acc_ctrl),
      .rd_data  (rd_data),
      .result   (acc_result),
      .found    (found),
      .position (found_pos)
   );

   // A search starts as not found and turns to ok on its first match.
   always_comb begin
      final_status = done.status;
      if (done.op == alist_pkg::OP_SEARCH && found) final_status = alist_pkg::ST_OK;
   end

   // Length update, result assembly and capacity writes.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cap_in       = cap_ff;
      if (done.load) begin
         if (done.ok && done.op == alist_pkg::OP_INSERT) begin
            count_in = count_ff + alist_pkg::CNT_W'(1);
         end else if (done.ok && done.op == alist_pkg::OP_DELETE) begin
            count_in = count_ff - alist_pkg::CNT_W'(1);
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[alist_pkg::RSP_BITS-1:0] = {count_in, final_status, found_pos, acc_result};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) cap_in = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= alist_pkg::CFG_W'(alist_pkg::CAPACITY);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/alist_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; no package dependency.
module alist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/alist_acc.sv @@
// Reduction unit: delete capture, search match, exact sum and extrema.
// Depends on alist_pkg; fed one element per cycle by alist_seq.
module alist_acc (
   input  logic                              clock,
   input  alist_pkg::acc_ctrl_type           ctrl,
   input  logic [alist_pkg::DATA_W-1:0]      rd_data,
   output logic signed [alist_pkg::RES_W-1:0] result,
   output logic                              found,
   output logic [alist_pkg::ADDR_W-1:0]      position
);

   logic signed [alist_pkg::RES_W-1:0] acc_ff, acc_in;
   logic                               found_ff, found_in;
   logic [alist_pkg::ADDR_W-1:0]       pos_ff, pos_in;
   logic signed [alist_pkg::RES_W-1:0] data_ext;
   logic signed [alist_pkg::DATA_W-1:0] data_s, best_s;

   assign data_s   = signed'(rd_data);
   assign best_s   = signed'(acc_ff[alist_pkg::DATA_W-1:0]);
   assign data_ext = {{(alist_pkg::RES_W - alist_pkg::DATA_W){rd_data[alist_pkg::DATA_W-1]}},
                      rd_data};

   always_comb begin
      acc_in   = acc_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      if (ctrl.clear) begin
         acc_in   = '0;
         found_in = 1'b0;
         pos_in   = '0;
      end else if (ctrl.valid) begin
         case (ctrl.op)
            alist_pkg::OP_DELETE: begin
               if (ctrl.first) acc_in = data_ext;
            end
            alist_pkg::OP_SEARCH: begin
               if (!found_ff && rd_data == ctrl.key) begin
                  found_in = 1'b1;
                  pos_in   = ctrl.pos;
               end
            end
            alist_pkg::OP_SUM: begin
               acc_in = acc_ff + data_ext;
            end
            alist_pkg::OP_MAX: begin
               if (ctrl.first || data_s > best_s) acc_in = data_ext;
            end
            alist_pkg::OP_MIN: begin
               if (ctrl.first || data_s < best_s) acc_in = data_ext;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
   end

   assign result   = acc_ff;
   assign found    = found_ff;
   assign position = pos_ff;

endmodule

@@ hw/rtl/alist_seq.sv @@
// Request sequencer: checks a request, walks the element memory one entry per
// cycle and writes shifted entries back. Depends on alist_pkg.
module alist_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  alist_pkg::op_type                req_op,
   input  logic [alist_pkg::ADDR_W-1:0]     req_index,
   input  logic [alist_pkg::DATA_W-1:0]     req_value,
   input  logic [alist_pkg::CNT_W-1:0]      count,
   input  logic [alist_pkg::CNT_W-1:0]      cap_eff,
   input  logic                             rsp_free,
   input  logic [alist_pkg::DATA_W-1:0]     rd_data,
   output logic                             rd_en,
   output logic [alist_pkg::ADDR_W-1:0]     rd_addr,
   output logic                             wr_en,
   output logic [alist_pkg::ADDR_W-1:0]     wr_addr,
   output logic [alist_pkg::DATA_W-1:0]     wr_data,
   output alist_pkg::acc_ctrl_type          acc_ctrl,
   output alist_pkg::done_type              done
);

   alist_pkg::state_type            state_ff, state_in;
   alist_pkg::op_type               op_ff, op_in;
   alist_pkg::status_type           status_ff, status_in;
   logic                            ok_ff, ok_in;
   logic [alist_pkg::ADDR_W-1:0]    idx_ff, idx_in;
   logic [alist_pkg::DATA_W-1:0]    val_ff, val_in;
   logic [alist_pkg::CNT_W-1:0]     left_ff, left_in;
   logic [alist_pkg::ADDR_W-1:0]    raddr_ff, raddr_in;
   logic [alist_pkg::ADDR_W-1:0]    qaddr_ff, qaddr_in;
   logic                            rvalid_ff, rvalid_in;
   logic                            first_ff, first_in;

   logic                            accept;
   alist_pkg::status_type           chk_status;
   logic                            chk_ok;
   logic [alist_pkg::CNT_W-1:0]     chk_reads;
   logic [alist_pkg::ADDR_W-1:0]    chk_addr;
   logic [alist_pkg::CNT_W-1:0]     idx_ext;
   logic [alist_pkg::CNT_W-1:0]     count_m1;

   assign accept   = req_valid && (state_ff == alist_pkg::S_IDLE);
   assign idx_ext  = alist_pkg::CNT_W'(req_index);
   assign count_m1 = count - alist_pkg::CNT_W'(1);

   // Request check and length of the memory walk.
   always_comb begin
      chk_status = alist_pkg::ST_OK;
      chk_ok     = 1'b0;
      chk_reads  = '0;
      chk_addr   = '0;
      unique case (req_op) inside
         alist_pkg::OP_INSERT: begin
            if (count >= cap_eff) begin
               chk_status = alist_pkg::ST_FULL;
            end else if (idx_ext > count) begin
               chk_status = alist_pkg::ST_RANGE;
            end else begin
               chk_ok    = 1'b1;
               chk_reads = count - idx_ext;
               chk_addr  = count_m1[alist_pkg::ADDR_W-1:0];
            end
         end
         alist_pkg::OP_DELETE: begin
            if (count == '0) begin
               chk_status = alist_pkg::ST_EMPTY;
            end else if (idx_ext >= count) begin
               chk_status = alist_pkg::ST_RANGE;
            end else begin
               chk_ok    = 1'b1;
               chk_reads = count - idx_ext;
               chk_addr  = req_index;
            end
         end
         alist_pkg::OP_SEARCH: begin
            chk_status = alist_pkg::ST_NOT_FOUND;
            chk_reads  = count;
         end
         alist_pkg::OP_SUM: begin
            chk_reads = count;
         end
         alist_pkg::OP_MAX, alist_pkg::OP_MIN: begin
            if (count == '0) begin
               chk_status = alist_pkg::ST_EMPTY;
            end else begin
               chk_reads = count;
            end
         end
         default: begin
            chk_status = alist_pkg::ST_OK;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         alist_pkg::S_IDLE: begin
            if (req_valid) begin
               if (chk_reads != '0) begin
                  state_in = alist_pkg::S_SCAN;
               end else if (req_op == alist_pkg::OP_INSERT && chk_ok) begin
                  state_in = alist_pkg::S_PUT;
               end else begin
                  state_in = alist_pkg::S_DONE;
               end
            end
         end
         alist_pkg::S_SCAN: begin
            if (left_ff == alist_pkg::CNT_W'(1)) state_in = alist_pkg::S_TAIL;
         end
         alist_pkg::S_TAIL: begin
            state_in = (op_ff == alist_pkg::OP_INSERT) ? alist_pkg::S_PUT : alist_pkg::S_DONE;
         end
         alist_pkg::S_PUT: begin
            state_in = alist_pkg::S_DONE;
         end
         alist_pkg::S_DONE: begin
            if (rsp_free) state_in = alist_pkg::S_IDLE;
         end
         default: begin
            state_in = alist_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs: memory port controls and handshakes.
   always_comb begin
      req_ready = (state_ff == alist_pkg::S_IDLE);
      rd_en     = (state_ff == alist_pkg::S_SCAN);
      rd_addr   = raddr_ff;
      wr_en     = 1'b0;
      wr_addr   = qaddr_ff;
      wr_data   = rd_data;
      if (state_ff == alist_pkg::S_PUT) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = val_ff;
      end else if (rvalid_ff && op_ff == alist_pkg::OP_INSERT) begin
         wr_en   = 1'b1;
         wr_addr = qaddr_ff + alist_pkg::ADDR_W'(1);
      end else if (rvalid_ff && op_ff == alist_pkg::OP_DELETE && !first_ff) begin
         wr_en   = 1'b1;
         wr_addr = qaddr_ff - alist_pkg::ADDR_W'(1);
      end
      acc_ctrl.clear = accept;
      acc_ctrl.op    = op_ff;
      acc_ctrl.valid = rvalid_ff;
      acc_ctrl.first = first_ff;
      acc_ctrl.pos   = qaddr_ff;
      acc_ctrl.key   = val_ff;
      done.load      = (state_ff == alist_pkg::S_DONE) && rsp_free;
      done.op        = op_ff;
      done.status    = status_ff;
      done.ok        = ok_ff;
   end

   // Request registers and walk counters.
   always_comb begin
      op_in     = op_ff;
      status_in = status_ff;
      ok_in     = ok_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      left_in   = left_ff;
      raddr_in  = raddr_ff;
      qaddr_in  = raddr_ff;
      rvalid_in = (state_ff == alist_pkg::S_SCAN);
      first_in  = rvalid_ff ? 1'b0 : first_ff;
      if (accept) begin
         op_in     = req_op;
         status_in = chk_status;
         ok_in     = chk_ok;
         idx_in    = req_index;
         val_in    = req_value;
         left_in   = chk_reads;
         raddr_in  = chk_addr;
         first_in  = 1'b1;
      end else if (state_ff == alist_pkg::S_SCAN) begin
         left_in  = left_ff - alist_pkg::CNT_W'(1);
         raddr_in = (op_ff == alist_pkg::OP_INSERT) ? raddr_ff - alist_pkg::ADDR_W'(1)
                                                    : raddr_ff + alist_pkg::ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= alist_pkg::S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
      op_ff     <= op_in;
      status_ff <= status_in;
      ok_ff     <= ok_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      left_ff   <= left_in;
      raddr_ff  <= raddr_in;
      qaddr_ff  <= qaddr_in;
      first_ff  <= first_in;
   end

endmodule

@@ hw/rtl/alist_checker.sv @@
// Port-level checks for the array list engine, bound to the top level.
// Depends on alist_pkg and on the port names of array_list_engine.
module alist_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [alist_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   // Requests taken whose results have not yet been delivered.
   logic [1:0] pend_ff, pend_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // The engine works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted on two cycles in a row");

   // No result without a request behind it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("result presented with no request outstanding");

   // At most one result waits while one more request is in work.
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_tready)
      else $error("third request accepted while two are outstanding");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind array_list_engine alist_checker u_alist_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
